[design/tpq_pkg.sv]
package tpq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 5;

  typedef enum logic [1:0] {
    OpAppend = 2'd0,
    OpInsert = 2'd1,
    OpRemove = 2'd2,
    OpPeek   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] payload;
    logic [DataW-1:0] rtime;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic by_time;
    logic pop;
  } cell_ctrl_t;

endpackage

[design/tpq_cell.sv]
module tpq_cell (
  input  logic                clk_i,
  input  tpq_pkg::cell_ctrl_t ctrl_i,
  input  tpq_pkg::entry_t     new_i,
  input  logic                occupied_i,
  input  tpq_pkg::entry_t     left_i,
  input  tpq_pkg::entry_t     right_i,
  input  logic                hit_i,
  output logic                hit_o,
  output tpq_pkg::entry_t     entry_o
);

  tpq_pkg::entry_t entry_q, entry_d;
  logic            take_here;

  // first free slot, or first entry later than the new one
  assign take_here = !occupied_i || (ctrl_i.by_time && (entry_q.rtime > new_i.rtime));
  assign hit_o     = hit_i || take_here;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.wr_en) begin
      if (hit_i) begin
        entry_d = left_i;
      end else if (take_here) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[design/time_ordered_packet_queue.sv]
// Bounded queue of tpq_pkg::Depth entries (payload handle, release time) held in a row of
// cells, head in cell 0. Append adds at the tail; insert places the entry after every
// entry with an equal or earlier release time. Remove returns and drops the head, peek
// returns it in place. All cells compare and shift in parallel, and a request is taken
// every cycle while the one-deep result register is free or being drained. A full queue
// drops a new entry with status full; remove or peek on an empty queue returns status
// empty with zero data. Occupancy is the count after the request.
module time_ordered_packet_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [tpq_pkg::DataW-1:0]    payload_i,
  input  logic [tpq_pkg::DataW-1:0]    release_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [tpq_pkg::DataW-1:0]    head_payload_o,
  output logic [tpq_pkg::DataW-1:0]    head_time_o,
  output logic [tpq_pkg::OccW-1:0]     occupancy_o
);

  localparam int unsigned N = tpq_pkg::Depth;

  logic [tpq_pkg::CntW-1:0] count_q, count_d;
  logic                     out_valid_q;
  tpq_pkg::status_e         status_q, status_d;
  tpq_pkg::entry_t          head_q, head_d;
  logic [tpq_pkg::OccW-1:0] occ_q, occ_d;

  logic                     accept, full, empty, is_wr;
  tpq_pkg::op_e             op;
  tpq_pkg::cell_ctrl_t      ctrl;
  tpq_pkg::entry_t          new_entry;
  tpq_pkg::entry_t          cells [N];
  logic [N:0]               hit;
  logic [tpq_pkg::OccW+tpq_pkg::CntW-1:0] occ_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = tpq_pkg::op_e'(operation_i);
  assign full       = (count_q == tpq_pkg::CntW'(N));
  assign empty      = (count_q == '0);
  assign is_wr      = (op == tpq_pkg::OpAppend) || (op == tpq_pkg::OpInsert);

  assign new_entry.payload = payload_i;
  assign new_entry.rtime   = release_time_i;

  assign ctrl.wr_en   = accept && is_wr && !full;
  assign ctrl.by_time = (op == tpq_pkg::OpInsert);
  assign ctrl.pop     = accept && (op == tpq_pkg::OpRemove) && !empty;

  assign hit[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    tpq_pkg::entry_t left_e, right_e;
    logic            occ;
    assign occ = (tpq_pkg::CntW'(g) < count_q);
    if (g == 0) begin : g_first
      assign left_e = new_entry;
    end else begin : g_mid
      assign left_e = cells[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_e = cells[g];
    end else begin : g_inner
      assign right_e = cells[g+1];
    end
    tpq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_i      (new_entry),
      .occupied_i (occ),
      .left_i     (left_e),
      .right_i    (right_e),
      .hit_i      (hit[g]),
      .hit_o      (hit[g+1]),
      .entry_o    (cells[g])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = tpq_pkg::StDone;
    head_d   = '0;
    if (is_wr) begin
      if (full) begin
        status_d = tpq_pkg::StFull;
      end else begin
        count_d = count_q + tpq_pkg::CntW'(1);
      end
    end else if (empty) begin
      status_d = tpq_pkg::StEmpty;
    end else begin
      head_d = cells[0];
      if (op == tpq_pkg::OpRemove) begin
        count_d = count_q - tpq_pkg::CntW'(1);
      end
    end
    occ_ext = {{tpq_pkg::OccW{1'b0}}, count_d};
    occ_d   = occ_ext[tpq_pkg::OccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      head_q   <= head_d;
      occ_q    <= occ_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign head_payload_o = head_q.payload;
  assign head_time_o    = head_q.rtime;
  assign occupancy_o    = occ_q;

endmodule
